/* design/lldq_pkg.sv */
// lldq_pkg: shared types and constants for the linked list deque engine
// no dependencies; imported by linked_list_deque_engine
`timescale 1ns / 1ps

package lldq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int OCC_W        = 5;
  localparam int IN_DATA_W    = 32;
  localparam int IN_USER_W    = 3;
  localparam int OUT_DATA_W   = 40;
  localparam int OUT_USER_W   = 2;

  typedef enum logic [IN_USER_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ_FWD   = 3'd5,
    OP_READ_BWD   = 3'd6,
    OP_NONE       = 3'd7
  } op_e;

  typedef enum logic [OUT_USER_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

/* design/linked_list_deque_engine.sv */
// linked_list_deque_engine: bounded doubly linked deque of signed 32-bit values
// depends on lldq_pkg and lldq_ram (value, next link and prior link stores)
//
//   channel  dir  tdata                              tuser        tlast
//   s_axis   in   item_value[31:0]                   op[2:0]      -
//   m_axis   out  out_value[31:0], occupancy[36:32]  status[1:0]  last
//
// one operation at a time; a new transfer is taken whenever the sequencer is idle
// push: EXEC writes the node, LINK rewrites a neighbor link if one exists, then EMIT
// pop: EXEC, RD, RSP, EMIT; remove: RD and RSP per node visited, between EXEC and EMIT
// read: RD and RSP per element after EXEC; node walks wait on the registered node stores
// reset empties the list at once through the free map; stores need no clearing
// results wait in one output register; a stalled m_axis holds the sequencer
`timescale 1ns / 1ps

module linked_list_deque_engine #(
  parameter int CAPACITY = lldq_pkg::DEF_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lldq_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // item_value
  input  logic [lldq_pkg::IN_USER_W-1:0]  s_axis_tuser,   // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lldq_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // out_value, occupancy, zero pad
  output logic [lldq_pkg::OUT_USER_W-1:0] m_axis_tuser,   // status
  output logic                            m_axis_tlast
);

  import lldq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PAD_W = OUT_DATA_W - VALUE_W - OCC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RSP  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    remain_q, remain_d;
  logic [IDX_W-1:0]    front_q, front_d;
  logic [IDX_W-1:0]    back_q, back_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [CAPACITY-1:0] free_q, free_d;
  logic                out_valid_q, out_valid_d;

  op_e                 op_q, op_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [IDX_W-1:0]    node_q, node_d;
  logic [IDX_W-1:0]    link_q, link_d;
  logic [VALUE_W-1:0]  res_value_q, res_value_d;
  status_e             res_status_q, res_status_d;
  logic [VALUE_W-1:0]  out_value_q, out_value_d;
  status_e             out_status_q, out_status_d;
  logic                out_last_q, out_last_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  logic                val_we, next_we, prior_we, rd_en;
  logic [IDX_W-1:0]    val_waddr, next_waddr, prior_waddr;
  logic [VALUE_W-1:0]  val_wdata;
  logic [IDX_W-1:0]    next_wdata, prior_wdata;
  logic [VALUE_W-1:0]  rd_value;
  logic [IDX_W-1:0]    rd_next, rd_prior;

  logic [IDX_W-1:0]    alloc_idx;
  logic                slot_free;
  logic                in_xfer;
  logic                is_push, is_pop, is_read;

  // lowest free node
  always_comb begin
    alloc_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        alloc_idx = IDX_W'(i);
      end
    end
  end

  assign slot_free = !out_valid_q || m_axis_tready;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign is_push   = (op_q inside {OP_PUSH_BACK, OP_PUSH_FRONT});
  assign is_pop    = (op_q inside {OP_POP_FRONT, OP_POP_BACK});
  assign is_read   = (op_q inside {OP_READ_FWD, OP_READ_BWD});

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    front_d      = front_q;
    back_d       = back_q;
    cur_d        = cur_q;
    free_d       = free_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    val_d        = val_q;
    node_d       = node_q;
    link_d       = link_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_occ_d    = out_occ_q;

    val_we       = 1'b0;
    val_waddr    = alloc_idx;
    val_wdata    = val_q;
    next_we      = 1'b0;
    next_waddr   = alloc_idx;
    next_wdata   = alloc_idx;
    prior_we     = 1'b0;
    prior_waddr  = alloc_idx;
    prior_wdata  = alloc_idx;
    rd_en        = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d  = op_e'(s_axis_tuser);
          val_d = s_axis_tdata[VALUE_W-1:0];
          if (op_e'(s_axis_tuser) != OP_NONE) begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (is_push) begin
          res_value_d = val_q;
          if (free_q == '0) begin
            res_status_d = ST_FULL;
            state_d      = S_EMIT;
          end else begin
            res_status_d = ST_OK;
            val_we       = 1'b1;
            next_we      = 1'b1;
            prior_we     = 1'b1;
            if (count_q != '0 && op_q == OP_PUSH_FRONT) begin
              next_wdata = front_q;
            end
            if (count_q != '0 && op_q == OP_PUSH_BACK) begin
              prior_wdata = back_q;
            end
            free_d[alloc_idx] = 1'b0;
            count_d           = count_q + CNT_W'(1);
            node_d            = alloc_idx;
            if (count_q == '0) begin
              front_d = alloc_idx;
              back_d  = alloc_idx;
              state_d = S_EMIT;
            end else if (op_q == OP_PUSH_BACK) begin
              link_d  = back_q;
              back_d  = alloc_idx;
              state_d = S_LINK;
            end else begin
              link_d  = front_q;
              front_d = alloc_idx;
              state_d = S_LINK;
            end
          end
        end else if (count_q == '0) begin
          res_value_d  = '0;
          res_status_d = (op_q == OP_REMOVE) ? ST_NOT_FOUND : ST_EMPTY;
          state_d      = S_EMIT;
        end else begin
          cur_d    = (op_q inside {OP_POP_BACK, OP_READ_BWD}) ? back_q : front_q;
          remain_d = count_q;
          state_d  = S_RD;
        end
      end
      S_LINK: begin
        if (op_q == OP_PUSH_BACK) begin
          next_we    = 1'b1;
          next_waddr = link_q;
          next_wdata = node_q;
        end else begin
          prior_we    = 1'b1;
          prior_waddr = link_q;
          prior_wdata = node_q;
        end
        state_d = S_EMIT;
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_RSP;
      end
      S_RSP: begin
        if (is_read) begin
          if (slot_free) begin
            out_valid_d  = 1'b1;
            out_value_d  = rd_value;
            out_status_d = ST_OK;
            out_last_d   = (remain_q == CNT_W'(1));
            out_occ_d    = OCC_W'(count_q);
            if (remain_q == CNT_W'(1)) begin
              state_d = S_IDLE;
            end else begin
              cur_d    = (op_q == OP_READ_FWD) ? rd_next : rd_prior;
              remain_d = remain_q - CNT_W'(1);
              state_d  = S_RD;
            end
          end
        end else if (is_pop || rd_value == val_q) begin
          // unlink the current node
          if (cur_q == front_q) begin
            front_d = rd_next;
          end else begin
            next_we    = 1'b1;
            next_waddr = rd_prior;
            next_wdata = rd_next;
          end
          if (cur_q == back_q) begin
            back_d = rd_prior;
          end else begin
            prior_we    = 1'b1;
            prior_waddr = rd_next;
            prior_wdata = rd_prior;
          end
          free_d[cur_q] = 1'b1;
          count_d       = count_q - CNT_W'(1);
          res_value_d   = rd_value;
          res_status_d  = ST_OK;
          state_d       = S_EMIT;
        end else if (remain_q == CNT_W'(1)) begin
          res_value_d  = '0;
          res_status_d = ST_NOT_FOUND;
          state_d      = S_EMIT;
        end else begin
          cur_d    = rd_next;
          remain_d = remain_q - CNT_W'(1);
          state_d  = S_RD;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          out_last_d   = 1'b1;
          out_occ_d    = OCC_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      front_q     <= '0;
      back_q      <= '0;
      cur_q       <= '0;
      free_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      front_q     <= front_d;
      back_q      <= back_d;
      cur_q       <= cur_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    node_q       <= node_d;
    link_q       <= link_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    out_occ_q    <= out_occ_d;
  end

  lldq_ram #(.Width(VALUE_W), .Depth(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (cur_q),
    .rdata_o (rd_value)
  );

  lldq_ram #(.Width(IDX_W), .Depth(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (rd_en),
    .raddr_i (cur_q),
    .rdata_o (rd_next)
  );

  lldq_ram #(.Width(IDX_W), .Depth(CAPACITY)) u_prior_ram (
    .clk_i   (clk_i),
    .we_i    (prior_we),
    .waddr_i (prior_waddr),
    .wdata_i (prior_wdata),
    .re_i    (rd_en),
    .raddr_i (cur_q),
    .rdata_o (rd_prior)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_occ_q, out_value_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= CAPACITY)
    else $error("element count exceeds capacity");

  a_free_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_q) + int'(count_q) == CAPACITY)
    else $error("free map disagrees with element count");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_e'(s_axis_tuser) != OP_NONE) |=> state_q == S_EXEC)
    else $error("accepted operation did not start");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_value_q) && $stable(out_occ_q))
    else $error("pending result overwritten");
`endif

endmodule

/* design/lldq_ram.sv */
// lldq_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the node value and link stores
`timescale 1ns / 1ps

module lldq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for linked_list_deque_engine
// keeps its own deque of values to predict every result transfer, with random idling on both sides
// depends on lldq_pkg and the engine rtl
`timescale 1ns / 1ps

module tb_top;
  import lldq_pkg::*;

  localparam int DEPTH       = DEF_CAPACITY;
  localparam int RANDOM_OPS  = 185;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [OCC_W-1:0]   occ;
    status_e            status;
    logic               last;
  } result_t;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  op_e                   s_axis_tuser = OP_NONE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  request_t           op_backlog[$];
  result_t            owed_results[$];
  logic [VALUE_W-1:0] deque_values[$];
  int                 total_requests = 0;
  int                 accepted = 0;
  int                 errors = 0;
  int                 cycles = 0;

  linked_list_deque_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // item_value
    .s_axis_tuser  (s_axis_tuser),   // op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_value, occupancy, zero pad
    .m_axis_tuser  (m_axis_tuser),   // status
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  function automatic int idle_phase();
    return (total_requests == 0) ? 0 : (accepted * 4) / total_requests;
  endfunction

  function automatic bit sender_idles();
    int ph;
    ph = idle_phase();
    return (ph == 1 && $urandom_range(99) < 57) || (ph == 3 && $urandom_range(99) < 7);
  endfunction

  function automatic bit receiver_stalls();
    int ph;
    ph = idle_phase();
    return (ph == 2 && $urandom_range(99) < 57) || (ph == 3 && $urandom_range(99) < 7);
  endfunction

  function automatic void owe(logic [VALUE_W-1:0] value, status_e status, logic last);
    result_t r;
    r.value  = value;
    r.occ    = OCC_W'(deque_values.size());
    r.status = status;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  function automatic void apply_deque_op(op_e op, logic [VALUE_W-1:0] value);
    int hit;
    int n;
    logic [VALUE_W-1:0] got;
    hit = -1;
    n = deque_values.size();
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (n == DEPTH) begin
          owe(value, ST_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_BACK) deque_values.push_back(value);
          else deque_values.push_front(value);
          owe(value, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (n == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          got = (op == OP_POP_FRONT) ? deque_values.pop_front() : deque_values.pop_back();
          owe(got, ST_OK, 1'b1);
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < n; i++) begin
          if (deque_values[i] == value) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          deque_values.delete(hit);
          owe(value, ST_OK, 1'b1);
        end else begin
          owe('0, ST_NOT_FOUND, 1'b1);
        end
      end
      OP_READ_FWD, OP_READ_BWD: begin
        if (n == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            owe(deque_values[op == OP_READ_FWD ? i : n - 1 - i], ST_OK, i == n - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // driver: the transfer on the bus is predicted when it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_deque_op(s_axis_tuser, s_axis_tdata);
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_backlog.size() > 0 && !sender_idles()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= op_backlog[0].op;
          s_axis_tdata  <= op_backlog[0].value;
          void'(op_backlog.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !receiver_stalls();
  end

  // monitor
  always @(posedge clk_i) begin
    result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: value %h occ %0d status %0d last %0b",
                   m_axis_tdata[VALUE_W-1:0], m_axis_tdata[VALUE_W+OCC_W-1:VALUE_W],
                   m_axis_tuser, m_axis_tlast);
      end else begin
        exp = owed_results.pop_front();
        if (m_axis_tdata[VALUE_W-1:0] !== exp.value ||
            m_axis_tdata[VALUE_W+OCC_W-1:VALUE_W] !== exp.occ ||
            m_axis_tuser !== exp.status || m_axis_tlast !== exp.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected value %h occ %0d status %0d last %0b, got %h %0d %0d %0b",
                     exp.value, exp.occ, exp.status, exp.last,
                     m_axis_tdata[VALUE_W-1:0], m_axis_tdata[VALUE_W+OCC_W-1:VALUE_W],
                     m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_op(op_e op, logic [VALUE_W-1:0] value);
    request_t req;
    req.op    = op;
    req.value = value;
    op_backlog.push_back(req);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom;
    if (sel < 80) return VALUE_W'($signed($urandom_range(0, 7)) - 4);
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  initial begin
    logic [VALUE_W-1:0] recent[8];
    int recent_idx;
    int made;
    int epoch_left;
    bit filling;
    int sel;
    logic [VALUE_W-1:0] v;

    recent_idx = 0;
    made = 0;
    epoch_left = 0;
    filling = 1'b0;
    foreach (recent[i]) recent[i] = '0;

    // empty list corner cases
    queue_op(OP_POP_FRONT, 32'h1234_5678);
    queue_op(OP_POP_BACK, 32'h0);
    queue_op(OP_REMOVE, 32'h5);
    queue_op(OP_READ_FWD, 32'h0);
    queue_op(OP_READ_BWD, 32'h0);
    queue_op(OP_NONE, 32'hffff_ffff);
    // extremes, duplicate value, both ends
    queue_op(OP_PUSH_BACK, 32'h8000_0000);
    queue_op(OP_PUSH_FRONT, 32'h7fff_ffff);
    queue_op(OP_PUSH_BACK, 32'h0000_0000);
    queue_op(OP_PUSH_FRONT, 32'hffff_ffff);
    queue_op(OP_PUSH_BACK, 32'h8000_0000);
    queue_op(OP_READ_FWD, 32'h0);
    queue_op(OP_READ_BWD, 32'h0);
    // first match, absent, front node, back node
    queue_op(OP_REMOVE, 32'h8000_0000);
    queue_op(OP_REMOVE, 32'h0003_0039);
    queue_op(OP_REMOVE, 32'hffff_ffff);
    queue_op(OP_REMOVE, 32'h8000_0000);
    queue_op(OP_POP_FRONT, 32'h0);
    queue_op(OP_POP_BACK, 32'h0);
    queue_op(OP_READ_FWD, 32'h0);

    // alternating fill and drain epochs so the list reaches full and empty often
    while (made < RANDOM_OPS) begin
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(20, 40);
        filling = !filling;
      end
      sel = $urandom_range(99);
      if (sel < (filling ? 60 : 20)) begin
        v = pick_value();
        recent[recent_idx] = v;
        recent_idx = (recent_idx + 1) % 8;
        queue_op($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, v);
      end else if (sel < (filling ? 70 : 60)) begin
        queue_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
      end else if (sel < 80) begin
        v = ($urandom_range(99) < 60) ? recent[$urandom_range(7)] : pick_value();
        queue_op(OP_REMOVE, v);
      end else if (sel < 97) begin
        queue_op($urandom_range(1) ? OP_READ_FWD : OP_READ_BWD, $urandom);
      end else begin
        // ignored opcode, does not count toward the random total
        queue_op(OP_NONE, $urandom);
        continue;
      end
      made++;
      epoch_left--;
    end
    total_requests = op_backlog.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted < total_requests || owed_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (errors == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lldq_pkg.sv
design/lldq_ram.sv
design/linked_list_deque_engine.sv
tb/tb_top.sv
